// ===== rtl/core/rtae_pkg.sv =====
// ----------------------------------------------------------------------------
// rtae_pkg - shared types and constants for the R-type ALU execute core
// Command and status codes, function codes and register file geometry.
// ----------------------------------------------------------------------------
`default_nettype none

package rtae_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned REG_DEPTH = 32;
  localparam int unsigned REG_IDX_W = $clog2(REG_DEPTH);
  localparam int unsigned FUNCT_W   = 6;

  typedef logic [DATA_W-1:0]    data_t;
  typedef logic [REG_IDX_W-1:0] reg_idx_t;
  typedef logic [FUNCT_W-1:0]   funct_t;

  typedef enum logic [1:0] {
    CMD_EXEC    = 2'd0,
    CMD_SYSCALL = 2'd1,
    CMD_WR_REG  = 2'd2,
    CMD_SET_PC  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK            = 2'd0,
    ST_UNDEF_FUNCT   = 2'd1,
    ST_UNKNOWN_SCALL = 2'd2
  } status_t;

  localparam funct_t FN_JR  = 6'd8;
  localparam funct_t FN_ADD = 6'd32;
  localparam funct_t FN_SUB = 6'd34;
  localparam funct_t FN_AND = 6'd36;
  localparam funct_t FN_OR  = 6'd37;
  localparam funct_t FN_XOR = 6'd38;
  localparam funct_t FN_NOR = 6'd39;
  localparam funct_t FN_SLT = 6'd42;

  localparam data_t    EXIT_CODE   = 32'd10;
  localparam data_t    PC_STEP     = 32'd4;
  localparam reg_idx_t SYSCALL_REG = 5'd2;

endpackage

`default_nettype wire

// ===== rtl/core/rtae_if.sv =====
// ----------------------------------------------------------------------------
// rtae_if - request and result channels of the R-type ALU execute core
// Valid/ready channels; a request moves when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface rtae_in_if;
  logic              valid;
  logic              ready;
  rtae_pkg::cmd_t    command;
  rtae_pkg::reg_idx_t dest_reg;
  rtae_pkg::reg_idx_t src_a_reg;
  rtae_pkg::reg_idx_t src_b_reg;
  rtae_pkg::funct_t  funct;
  rtae_pkg::data_t   load_value;

  modport source (output valid, command, dest_reg, src_a_reg, src_b_reg, funct,
                  load_value, input ready);
  modport sink   (input valid, command, dest_reg, src_a_reg, src_b_reg, funct,
                  load_value, output ready);
endinterface

interface rtae_out_if;
  logic                valid;
  logic                ready;
  rtae_pkg::data_t     pc_value;
  logic                wrote_reg;
  rtae_pkg::reg_idx_t  written_index;
  rtae_pkg::data_t     written_value;
  rtae_pkg::status_t   status;
  logic                exit_request;

  modport source (output valid, pc_value, wrote_reg, written_index, written_value,
                  status, exit_request, input ready);
  modport sink   (input valid, pc_value, wrote_reg, written_index, written_value,
                  status, exit_request, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/rtae_ram.sv =====
// ----------------------------------------------------------------------------
// rtae_ram - generic RAM, one write port and two registered read ports
// Read data updates only on a read enable; reads return the old contents.
// ----------------------------------------------------------------------------
`default_nettype none

module rtae_ram #(
  parameter int unsigned WIDTH = rtae_pkg::DATA_W,
  parameter int unsigned DEPTH = rtae_pkg::REG_DEPTH,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr_a,
  input  wire logic [AW-1:0]    raddr_b,
  output logic      [WIDTH-1:0] rdata_a,
  output logic      [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_a_r;
  logic [WIDTH-1:0] rdata_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_a_r <= mem_r[raddr_a];
      rdata_b_r <= mem_r[raddr_b];
    end
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

`default_nettype wire

// ===== rtl/core/r_type_alu_execute_core.sv =====
// ----------------------------------------------------------------------------
// r_type_alu_execute_core - R-type ALU execute with register file and PC
// Executes add/sub/and/or/xor/nor/slt and jr, syscall exit checks and
// register / PC preloads, one request per clock while results drain.
// ----------------------------------------------------------------------------
//
//   channel    direction  handshake        payload
//   ---------  ---------  ---------------  ------------------------------------
//   in_chan    in         valid / ready    command, reg indices, funct, value
//   out_chan   out        valid / ready    pc, write report, status, exit flag
//
// Flow   : one request per clock while results drain; a result is registered
//          after the register file read, then the execute stage.
// Memory : the register file is a RAM with two registered read ports; its
//          single write port and the execute stage set the one-per-clock rate.
// Reset  : clears the pipeline valids, the PC and the per-entry valid flags;
//          an entry never written since reset reads as zero, no clearing pass.
// Stalls : a held result stops the execute stage, which in turn drops ready.
// ----------------------------------------------------------------------------
`default_nettype none

module r_type_alu_execute_core (
  input wire logic   clk,
  input wire logic   rst_n,
  rtae_in_if.sink    in_chan,
  rtae_out_if.source out_chan
);

  // Operand stage: request fields captured alongside the RAM read
  logic                s1_vld_r;
  rtae_pkg::cmd_t      s1_cmd_r;
  rtae_pkg::reg_idx_t  s1_rd_r;
  rtae_pkg::funct_t    s1_funct_r;
  rtae_pkg::data_t     s1_val_r;

  // Per-entry written-since-reset flags and their snapshot for each operand
  logic [rtae_pkg::REG_DEPTH-1:0] reg_vld_r;
  logic                           opa_vld_r;
  logic                           opb_vld_r;

  // Bypass of a write that lands on the same edge as the RAM read
  logic                byp_a_r;
  logic                byp_b_r;
  rtae_pkg::data_t     byp_val_r;

  rtae_pkg::data_t     prog_cnt_r;
  rtae_pkg::data_t     prog_cnt_nxt;

  // Result register
  logic                out_vld_r;
  rtae_pkg::data_t     out_pc_r;
  logic                out_wrote_r;
  rtae_pkg::reg_idx_t  out_idx_r;
  rtae_pkg::data_t     out_wval_r;
  rtae_pkg::status_t   out_status_r;
  logic                out_exit_r;

  logic                accept;
  logic                adv;
  rtae_pkg::reg_idx_t  rd_addr_a;
  rtae_pkg::data_t     ram_a;
  rtae_pkg::data_t     ram_b;
  rtae_pkg::data_t     op_a;
  rtae_pkg::data_t     op_b;
  rtae_pkg::data_t     alu_res;
  logic                alu_hit;
  logic                exe_wr;
  rtae_pkg::reg_idx_t  exe_widx;
  rtae_pkg::data_t     exe_wval;
  rtae_pkg::status_t   exe_status;
  logic                exe_exit;
  logic                wr_en;

  // Advance the execute stage whenever the result register is free or drains
  assign adv    = s1_vld_r && (!out_vld_r || out_chan.ready);
  assign accept = in_chan.valid && in_chan.ready;
  assign wr_en  = adv && exe_wr;

  assign in_chan.ready = !s1_vld_r || adv;

  // A syscall reads register 2 on port A; rs is unused for it
  assign rd_addr_a = (in_chan.command == rtae_pkg::CMD_SYSCALL) ?
                     rtae_pkg::SYSCALL_REG : in_chan.src_a_reg;

  rtae_ram #(
    .WIDTH (rtae_pkg::DATA_W),
    .DEPTH (rtae_pkg::REG_DEPTH)
  ) u_regfile (
    .clk     (clk),
    .we      (wr_en),
    .waddr   (exe_widx),
    .wdata   (exe_wval),
    .re      (accept),
    .raddr_a (rd_addr_a),
    .raddr_b (in_chan.src_b_reg),
    .rdata_a (ram_a),
    .rdata_b (ram_b)
  );

  // Operand select: same-edge bypass first, then unwritten entries read zero
  always_comb begin
    op_a = byp_a_r ? byp_val_r : (opa_vld_r ? ram_a : '0);
    op_b = byp_b_r ? byp_val_r : (opb_vld_r ? ram_b : '0);
  end

  always_comb begin
    alu_hit = 1'b1;
    alu_res = '0;
    case (s1_funct_r)
      rtae_pkg::FN_ADD: alu_res = op_a + op_b;
      rtae_pkg::FN_SUB: alu_res = op_a - op_b;
      rtae_pkg::FN_AND: alu_res = op_a & op_b;
      rtae_pkg::FN_OR:  alu_res = op_a | op_b;
      rtae_pkg::FN_XOR: alu_res = op_a ^ op_b;
      rtae_pkg::FN_NOR: alu_res = ~(op_a | op_b);
      rtae_pkg::FN_SLT: alu_res = {{(rtae_pkg::DATA_W-1){1'b0}},
                                   ($signed(op_a) < $signed(op_b))};
      default:          alu_hit = 1'b0;
    endcase
  end

  always_comb begin
    exe_wr       = 1'b0;
    exe_widx     = '0;
    exe_wval     = '0;
    exe_status   = rtae_pkg::ST_OK;
    exe_exit     = 1'b0;
    prog_cnt_nxt = prog_cnt_r;
    case (s1_cmd_r)
      rtae_pkg::CMD_EXEC: begin
        if (alu_hit) begin
          exe_wr       = 1'b1;
          exe_widx     = s1_rd_r;
          exe_wval     = alu_res;
          prog_cnt_nxt = prog_cnt_r + rtae_pkg::PC_STEP;
        end else if (s1_funct_r == rtae_pkg::FN_JR) begin
          prog_cnt_nxt = op_a;
        end else begin
          exe_status = rtae_pkg::ST_UNDEF_FUNCT;
        end
      end
      rtae_pkg::CMD_SYSCALL: begin
        if (op_a == rtae_pkg::EXIT_CODE) begin
          exe_exit = 1'b1;
        end else begin
          exe_status = rtae_pkg::ST_UNKNOWN_SCALL;
        end
      end
      rtae_pkg::CMD_WR_REG: begin
        exe_wr   = 1'b1;
        exe_widx = s1_rd_r;
        exe_wval = s1_val_r;
      end
      rtae_pkg::CMD_SET_PC: begin
        prog_cnt_nxt = s1_val_r;
      end
      default: begin
        prog_cnt_nxt = prog_cnt_r;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
      reg_vld_r  <= '0;
      prog_cnt_r <= '0;
    end else begin
      if (accept) begin
        s1_vld_r <= 1'b1;
      end else if (adv) begin
        s1_vld_r <= 1'b0;
      end
      if (adv) begin
        out_vld_r  <= 1'b1;
        prog_cnt_r <= prog_cnt_nxt;
      end else if (out_chan.ready) begin
        out_vld_r <= 1'b0;
      end
      if (wr_en) begin
        reg_vld_r[exe_widx] <= 1'b1;
      end
    end
  end

  // Payload: capture the request and its bypass/valid snapshot
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd_r   <= in_chan.command;
      s1_rd_r    <= in_chan.dest_reg;
      s1_funct_r <= in_chan.funct;
      s1_val_r   <= in_chan.load_value;
      opa_vld_r  <= reg_vld_r[rd_addr_a];
      opb_vld_r  <= reg_vld_r[in_chan.src_b_reg];
      byp_a_r    <= wr_en && (exe_widx == rd_addr_a);
      byp_b_r    <= wr_en && (exe_widx == in_chan.src_b_reg);
      byp_val_r  <= exe_wval;
    end
    if (adv) begin
      out_pc_r     <= prog_cnt_nxt;
      out_wrote_r  <= exe_wr;
      out_idx_r    <= exe_widx;
      out_wval_r   <= exe_wval;
      out_status_r <= exe_status;
      out_exit_r   <= exe_exit;
    end
  end

  assign out_chan.valid         = out_vld_r;
  assign out_chan.pc_value      = out_pc_r;
  assign out_chan.wrote_reg     = out_wrote_r;
  assign out_chan.written_index = out_idx_r;
  assign out_chan.written_value = out_wval_r;
  assign out_chan.status        = out_status_r;
  assign out_chan.exit_request  = out_exit_r;

  // Hold off new requests while the operand stage is full and cannot drain
  a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && out_vld_r && !out_chan.ready) |-> !in_chan.ready)
    else $error("request taken while execute stage stalled");

  // An ALU operation advances the PC by one step
  a_pc_step: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s1_cmd_r == rtae_pkg::CMD_EXEC && alu_hit) |=>
    (prog_cnt_r == $past(prog_cnt_r) + rtae_pkg::PC_STEP))
    else $error("PC did not advance after ALU operation");

  // An exit request comes with ok status and no register write
  a_exit_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_exit_r) |-> (out_status_r == rtae_pkg::ST_OK && !out_wrote_r))
    else $error("exit request with write or error status");

  // The result register reports the PC that the core holds
  a_pc_match: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !s1_vld_r) |-> (out_pc_r == prog_cnt_r))
    else $error("reported PC differs from PC register");

endmodule

`default_nettype wire
